// ===== hw/rtl/i2rd_pkg.sv =====
// Shared types and constants of the integer-to-radix-digits block.
// Used by every module of the block except i2rd_ram; depends on nothing.
`default_nettype none

package i2rd_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int MAX_RADIX  = 16;

  localparam int WORD_W      = 64;
  localparam int CHUNK_W     = 8;
  localparam int NUM_CHUNKS  = WORD_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 8;
  localparam int ALPHA_W     = 2 * WORD_W;
  localparam int RADIX_W     = 5;
  localparam int LEN_W       = 7;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int CFG_IDX_W   = 2;

  localparam logic [RADIX_W-1:0] RADIX_RST    = RADIX_W'(10);
  localparam logic [WORD_W-1:0]  CHARS_LO_RST = 64'h3736_3534_3332_3130;
  localparam logic [WORD_W-1:0]  CHARS_HI_RST = 64'h4645_4443_4241_3938;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX    = 2'd0,
    REG_CHARS_LO = 2'd1,
    REG_CHARS_HI = 2'd2
  } reg_idx_t;

  // One classified conversion job: magnitude, sign and top nonzero byte.
  typedef struct packed {
    logic [WORD_W-1:0]      mag;
    logic                   neg;
    logic [CHUNK_IDX_W-1:0] top;
  } job_t;

  // Configuration as seen by the conversion engine.
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic [ALPHA_W-1:0] chars;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2rd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module i2rd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2rd_front.sv =====
// Front end: takes input items, forms the magnitude and sign, finds the top byte.
// Depends on i2rd_pkg; feeds i2rd_queue.
`default_nettype none

module i2rd_front
  import i2rd_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_value,
  input  wire logic              in_unsigned_mode,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output job_t                   push_job
);

  logic                   neg;
  logic [WORD_W-1:0]      mag;
  logic [CHUNK_IDX_W-1:0] top;

  always_comb begin
    neg = !in_unsigned_mode && in_value[WORD_W-1];
    mag = neg ? (WORD_W'(0) - in_value) : in_value;
    // highest nonzero byte wins; zero maps to byte 0
    top = '0;
    for (int i = 0; i < NUM_CHUNKS; i++) begin
      if (mag[i*CHUNK_W +: CHUNK_W] != '0) begin
        top = CHUNK_IDX_W'(i);
      end
    end
  end

  assign push_valid   = in_valid;
  assign in_ready     = push_ready;
  assign push_job.mag = mag;
  assign push_job.neg = neg;
  assign push_job.top = top;

endmodule

`default_nettype wire

// ===== hw/rtl/i2rd_queue.sv =====
// Two-entry job queue between the front end and the conversion engine.
// Depends on i2rd_pkg for the job type.
`default_nettype none

module i2rd_queue
  import i2rd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  job_t      push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/i2rd_back.sv =====
// Conversion engine: divides byte by byte into a digit RAM, then streams
// characters most significant first. Depends on i2rd_pkg and i2rd_ram.
`default_nettype none

module i2rd_back
  import i2rd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  wire logic              job_valid,
  output logic                   job_ready,
  input  job_t                   job,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_digit_char,
  output logic                   out_minus_before,
  output logic                   out_last,
  output logic [LEN_W-1:0]       out_total_length
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t                 state_r, state_nxt;
  logic [WORD_W-1:0]      work_q_r, work_q_nxt;
  logic [CHUNK_IDX_W-1:0] idx_r, idx_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [CHUNK_IDX_W-1:0] qtop_r, qtop_nxt;
  logic                   qnz_r, qnz_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       remain_r, remain_nxt;
  logic                   pend_r, pend_nxt;
  logic                   pend_first_r, pend_first_nxt;
  logic                   pend_last_r, pend_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      char_r, char_nxt;
  logic                   minus_r, minus_nxt;
  logic                   last_r, last_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;

  logic [CHUNK_W-1:0]     div_in;
  logic [CHUNK_W-1:0]     q_byte;
  logic [DIGIT_W-1:0]     rem_c;
  logic [DIGIT_W:0]       trial;
  logic                   qnz_after;
  logic [CHUNK_IDX_W-1:0] qtop_after;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [DIGIT_W-1:0]     ram_rdata;
  logic                   slot_free;
  logic                   load;

  i2rd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (rem_c),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // One byte of long division by the radix: eight restoring steps on a 4-bit remainder.
  always_comb begin
    div_in = work_q_r[idx_r*CHUNK_W +: CHUNK_W];
    rem_c  = rem_r;
    q_byte = '0;
    trial  = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      trial = {rem_c, div_in[i]};
      if (trial >= cfg.radix) begin
        q_byte[i] = 1'b1;
        rem_c     = DIGIT_W'(trial - cfg.radix);
      end else begin
        rem_c = trial[DIGIT_W-1:0];
      end
    end
    qnz_after  = qnz_r || (q_byte != '0);
    qtop_after = qnz_r ? qtop_r : idx_r;
  end

  assign slot_free = !out_valid_r || out_ready;
  assign load      = (state_r == ST_EMIT) && pend_r && slot_free;
  assign ram_re    = (state_r == ST_EMIT) && (remain_r != '0) && (!pend_r || load);
  assign ram_raddr = ADDR_W'(remain_r - CNT_W'(1));
  assign ram_we    = (state_r == ST_DIV) && (idx_r == '0);
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign job_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    work_q_nxt     = work_q_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    qtop_nxt       = qtop_r;
    qnz_nxt        = qnz_r;
    count_nxt      = count_r;
    neg_nxt        = neg_r;
    remain_nxt     = remain_r;
    pend_nxt       = pend_r;
    pend_first_nxt = pend_first_r;
    pend_last_nxt  = pend_last_r;
    out_valid_nxt  = out_valid_r;
    char_nxt       = char_r;
    minus_nxt      = minus_r;
    last_nxt       = last_r;
    len_nxt        = len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          work_q_nxt = job.mag;
          neg_nxt    = job.neg;
          idx_nxt    = job.top;
          rem_nxt    = '0;
          qnz_nxt    = 1'b0;
          qtop_nxt   = '0;
          count_nxt  = '0;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        work_q_nxt[idx_r*CHUNK_W +: CHUNK_W] = q_byte;
        rem_nxt  = rem_c;
        qnz_nxt  = qnz_after;
        qtop_nxt = qtop_after;
        if (idx_r == '0) begin
          count_nxt = count_r + CNT_W'(1);
          if (!qnz_after || (count_r + CNT_W'(1) == CNT_W'(MAX_DIGITS))) begin
            remain_nxt = count_r + CNT_W'(1);
            pend_nxt   = 1'b0;
            state_nxt  = ST_EMIT;
          end else begin
            // next digit: restart on the quotient's top byte
            idx_nxt  = qtop_after;
            rem_nxt  = '0;
            qnz_nxt  = 1'b0;
            qtop_nxt = '0;
          end
        end else begin
          idx_nxt = idx_r - CHUNK_IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (ram_re) begin
          remain_nxt     = remain_r - CNT_W'(1);
          pend_first_nxt = (remain_r == count_r);
          pend_last_nxt  = (remain_r == CNT_W'(1));
          pend_nxt       = 1'b1;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if ((remain_r == '0) && !pend_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
      char_nxt      = cfg.chars[ram_rdata*CHAR_W +: CHAR_W];
      minus_nxt     = pend_first_r && neg_r;
      last_nxt      = pend_last_r;
      len_nxt       = pend_last_r ? (LEN_W'(count_r) + LEN_W'(neg_r)) : '0;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      remain_r    <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      qnz_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      remain_r    <= remain_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      qnz_r       <= qnz_nxt;
    end
    work_q_r     <= work_q_nxt;
    rem_r        <= rem_nxt;
    qtop_r       <= qtop_nxt;
    neg_r        <= neg_nxt;
    pend_first_r <= pend_first_nxt;
    pend_last_r  <= pend_last_nxt;
    char_r       <= char_nxt;
    minus_r      <= minus_nxt;
    last_r       <= last_nxt;
    len_r        <= len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_digit_char   = char_r;
  assign out_minus_before = minus_r;
  assign out_last         = last_r;
  assign out_total_length = len_r;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_to_radix_digits.sv =====
// Top level of the integer-to-radix-digits converter and its configuration registers.
// Depends on i2rd_pkg, i2rd_front, i2rd_queue and i2rd_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one 64-bit value and an unsigned-mode bit.
//   Output channel (out_valid/out_ready): one item per digit, most significant
//   first; the first carries out_minus_before for a negative signed value, the
//   last carries out_last and out_total_length (digits plus sign).
//   cfg_we/cfg_index/cfg_wdata write radix (index 0) and the two halves of the
//   16-character alphabet (indexes 1 and 2); write only while the block is idle.
// Operation:
//   Each digit is found by dividing the current dividend byte by byte from its
//   top nonzero byte down; the divider retires 8 quotient bits per cycle against
//   a 4-bit remainder. Digits stream out at one per cycle from the registered
//   digit RAM port while the receiver is ready.
// Reset (synchronous, active low) restores radix 10 and alphabet "0123456789ABCDEF"
// and empties the two-entry job queue. A stalled receiver holds the output
// register; the front end keeps accepting items until the queue is full.
`default_nettype none

module integer_to_radix_digits
  import i2rd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WORD_W-1:0]    in_value,
  input  wire logic                 in_unsigned_mode,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [CHAR_W-1:0]    out_digit_char,
  output logic                      out_minus_before,
  output logic                      out_last,
  output logic      [LEN_W-1:0]     out_total_length,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_wdata
);

  logic [RADIX_W-1:0] radix_r;
  logic [WORD_W-1:0]  chars_lo_r;
  logic [WORD_W-1:0]  chars_hi_r;
  cfg_t               cfg;
  logic               push_valid;
  logic               push_ready;
  job_t               push_job;
  logic               pop_valid;
  logic               pop_ready;
  job_t               pop_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RST;
      chars_lo_r <= CHARS_LO_RST;
      chars_hi_r <= CHARS_HI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIX:    radix_r    <= cfg_wdata[RADIX_W-1:0];
        REG_CHARS_LO: chars_lo_r <= cfg_wdata;
        REG_CHARS_HI: chars_hi_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // clamp the radix into the supported range
  always_comb begin
    priority if (radix_r < RADIX_W'(2)) begin
      cfg.radix = RADIX_W'(2);
    end else if (radix_r > RADIX_W'(MAX_RADIX)) begin
      cfg.radix = RADIX_W'(MAX_RADIX);
    end else begin
      cfg.radix = radix_r;
    end
    cfg.chars = {chars_hi_r, chars_lo_r};
  end

  i2rd_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_unsigned_mode (in_unsigned_mode),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_job         (push_job)
  );

  i2rd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  i2rd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .job_valid        (pop_valid),
    .job_ready        (pop_ready),
    .job              (pop_job),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digit_char   (out_digit_char),
    .out_minus_before (out_minus_before),
    .out_last         (out_last),
    .out_total_length (out_total_length)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/i2rd_checker.sv =====
// Port-level checks for integer_to_radix_digits, attached by bind.
// Depends on i2rd_pkg and the top level's port list.
`default_nettype none

module i2rd_checker
  import i2rd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [CHAR_W-1:0]    out_digit_char,
  input wire logic                 out_minus_before,
  input wire logic                 out_last,
  input wire logic [LEN_W-1:0]     out_total_length
);

  // set while inside a digit string, after its first item went out
  logic mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_r <= !out_last;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
      && $stable(out_last) && $stable(out_total_length))
    else $error("result changed while stalled");

  a_len_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_total_length == '0)
    else $error("length shown before the final digit");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_total_length != '0)
    else $error("final digit carries zero length");

  a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> !out_minus_before)
    else $error("minus flag after the first digit");

  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !mid_r |->
      out_total_length == (LEN_W'(1) + LEN_W'(out_minus_before)))
    else $error("wrong length for a one-digit string");

endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (.*);

`default_nettype wire
